### src/tld_pkg.sv
`timescale 1ns / 1ps

package tld_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int OPCODE_W        = 2;
    localparam int SLOT_W          = 4;
    localparam int STAMP_W         = 64;
    localparam int RENORM_SHIFT    = 48;
    localparam logic [STAMP_W-1:0] RENORM_LIMIT = 64'h0FFF_FFFF_FFFF_FFFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MARK   = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TRIM,
        S_SCAN,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic do_add;
        logic do_remove;
        logic trim_step;
        logic scan_init;
        logic scan_step;
        logic finish;
        logic emit;
        logic emit_rej;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_opcode op;
        logic    rejected;
        logic    need_renorm;
        logic    trim_done;
        logic    scan_done;
    } t_status;

endpackage

### src/timestamp_lru_device_table.sv
// LRU device table with 64-bit recency stamps. A request is taken when start is
// high and busy is low; its result appears on o_result_index/o_rejected for
// exactly one cycle with o_done high, and must be captured then, as there is
// no back-pressure. Add, mark-used without renormalisation, and any rejected
// request finish straight from the decode state. Remove trims the trailing
// invalid slots, one per cycle. Query, and mark-used with renormalisation,
// sweep the stamp memory one entry per cycle through its single registered
// read port. busy stays high while a request is in progress and is low again
// when o_done is high.
`timescale 1ns / 1ps

module timestamp_lru_device_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tld_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [tld_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic                          i_include_cleared,
    output logic                          o_done,
    output logic [tld_pkg::SLOT_W-1:0]    o_result_index,
    output logic                          o_rejected
);
    import tld_pkg::*;

    t_cmd    cmd;
    t_status status;

    tld_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tld_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_opcode          (i_opcode),
        .i_slot_index      (i_slot_index),
        .i_include_cleared (i_include_cleared),
        .o_status          (status),
        .o_done            (o_done),
        .o_result_index    (o_result_index),
        .o_rejected        (o_rejected)
    );

endmodule

### src/tld_ctrl.sv
`timescale 1ns / 1ps

module tld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tld_pkg::t_status  i_status,
    output tld_pkg::t_cmd     o_cmd,
    output logic              o_busy
);
    import tld_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.rejected) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_rej = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    unique case (i_status.op)
                        OP_ADD: begin
                            o_cmd.do_add = 1'b1;
                            o_cmd.emit   = 1'b1;
                            n_state      = S_IDLE;
                        end
                        OP_REMOVE: begin
                            o_cmd.do_remove = 1'b1;
                            n_state         = S_TRIM;
                        end
                        OP_MARK: begin
                            if (i_status.need_renorm) begin
                                o_cmd.scan_init = 1'b1;
                                n_state         = S_SCAN;
                            end else begin
                                o_cmd.finish = 1'b1;
                                o_cmd.emit   = 1'b1;
                                n_state      = S_IDLE;
                            end
                        end
                        OP_QUERY: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TRIM: begin
                if (i_status.trim_done) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.trim_step = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                o_cmd.emit   = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### src/tld_datapath.sv
`timescale 1ns / 1ps

module tld_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tld_pkg::t_cmd                 i_cmd,
    input  logic [tld_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [tld_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic                          i_include_cleared,
    output tld_pkg::t_status              o_status,
    output logic                          o_done,
    output logic [tld_pkg::SLOT_W-1:0]    o_result_index,
    output logic                          o_rejected
);
    import tld_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CW > SLOT_W) ? CW : SLOT_W;

    logic [STAMP_W-1:0]     r_stamps [TABLE_DEPTH];
    logic [STAMP_W-1:0]     r_rd_data;

    logic [TABLE_DEPTH-1:0] r_valid,   n_valid;
    logic [CW-1:0]          r_used,    n_used;
    logic [STAMP_W-1:0]     r_counter, n_counter;
    t_opcode                r_op,      n_op;
    logic [SLOT_W-1:0]      r_slot,    n_slot;
    logic                   r_incl,    n_incl;
    logic [CW-1:0]          r_scan,    n_scan;
    logic                   r_rd_vld,  n_rd_vld;
    logic [IW-1:0]          r_rd_idx,  n_rd_idx;
    logic [IW-1:0]          r_best,    n_best;
    logic [STAMP_W-1:0]     r_lowest,  n_lowest;
    logic                   r_done,    n_done;
    logic [SLOT_W-1:0]      r_res_idx, n_res_idx;
    logic                   r_rej,     n_rej;

    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [STAMP_W-1:0]     wr_data;

    logic                   full;
    logic                   slot_out;
    logic [IW-1:0]          last_idx;
    logic [STAMP_W-1:0]     counter_inc;

    assign full        = (r_used == CW'(TABLE_DEPTH));
    assign slot_out    = (CMP_W'(r_slot) >= CMP_W'(r_used));
    assign last_idx    = IW'(r_used - CW'(1));
    assign counter_inc = r_counter + STAMP_W'(1);

    always_comb begin
        o_status.op          = r_op;
        o_status.rejected    = ((r_op == OP_ADD) && full) ||
                               (((r_op == OP_REMOVE) || (r_op == OP_MARK)) && slot_out);
        o_status.need_renorm = (r_counter > RENORM_LIMIT);
        o_status.trim_done   = (r_used == '0) || r_valid[last_idx];
        o_status.scan_done   = (r_scan >= r_used) && !r_rd_vld;
    end

    always_comb begin
        n_valid   = r_valid;
        n_used    = r_used;
        n_counter = r_counter;
        n_op      = r_op;
        n_slot    = r_slot;
        n_incl    = r_incl;
        n_scan    = r_scan;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_best    = r_best;
        n_lowest  = r_lowest;
        n_done    = 1'b0;
        n_res_idx = r_res_idx;
        n_rej     = r_rej;
        rd_en     = 1'b0;
        rd_addr   = IW'(r_scan);
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;

        if (i_cmd.load) begin
            n_op   = t_opcode'(i_opcode);
            n_slot = i_slot_index;
            n_incl = i_include_cleared;
        end

        if (i_cmd.do_add) begin
            n_valid[IW'(r_used)] = 1'b1;
            n_counter            = counter_inc;
            n_used               = r_used + CW'(1);
            wr_en                = 1'b1;
            wr_addr              = IW'(r_used);
            wr_data              = counter_inc;
        end

        if (i_cmd.do_remove) begin
            n_valid[IW'(r_slot)] = 1'b0;
        end

        if (i_cmd.trim_step) begin
            n_used = r_used - CW'(1);
        end

        if (i_cmd.scan_init) begin
            n_scan   = '0;
            n_rd_vld = 1'b0;
            n_best   = '0;
            n_lowest = r_counter;
            if (r_op == OP_MARK) begin
                n_counter = r_counter >> RENORM_SHIFT;
            end
        end

        if (i_cmd.scan_step) begin
            rd_en    = (r_scan < r_used);
            n_rd_vld = rd_en;
            n_rd_idx = IW'(r_scan);
            if (rd_en) begin
                n_scan = r_scan + CW'(1);
            end
            if (r_rd_vld && r_valid[r_rd_idx]) begin
                if (r_op == OP_MARK) begin
                    // renormalise: write back entry read last cycle
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx;
                    wr_data = (r_rd_data >> RENORM_SHIFT) + STAMP_W'(1);
                end else if ((r_rd_data < r_lowest) &&
                             (r_incl || (r_rd_data != '0))) begin
                    n_lowest = r_rd_data;
                    n_best   = r_rd_idx;
                end
            end
        end

        if (i_cmd.finish) begin
            if (r_op == OP_MARK) begin
                n_counter = counter_inc;
                wr_en     = 1'b1;
                wr_addr   = IW'(r_slot);
                wr_data   = counter_inc;
            end else if ((r_op == OP_QUERY) && !r_incl && (r_used != '0)) begin
                wr_en   = 1'b1;
                wr_addr = r_best;
                wr_data = '0;
            end
        end

        if (i_cmd.emit) begin
            n_done = 1'b1;
            n_rej  = i_cmd.emit_rej;
            if (i_cmd.emit_rej) begin
                n_res_idx = '0;
            end else if (r_op == OP_ADD) begin
                n_res_idx = SLOT_W'(r_used);
            end else if (r_op == OP_QUERY) begin
                n_res_idx = SLOT_W'(r_best);
            end else begin
                n_res_idx = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stamps[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_stamps[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_used    <= '0;
            r_counter <= '0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_used    <= n_used;
            r_counter <= n_counter;
            r_rd_vld  <= n_rd_vld;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_slot    <= n_slot;
        r_incl    <= n_incl;
        r_scan    <= n_scan;
        r_rd_idx  <= n_rd_idx;
        r_best    <= n_best;
        r_lowest  <= n_lowest;
        r_res_idx <= n_res_idx;
        r_rej     <= n_rej;
    end

    assign o_done         = r_done;
    assign o_result_index = r_res_idx;
    assign o_rejected     = r_rej;

endmodule

### src/tld_checker.sv
`timescale 1ns / 1ps

module tld_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_done,
    input  logic [tld_pkg::SLOT_W-1:0]  i_result_index,
    input  logic                        i_rejected
);
    import tld_pkg::*;

    // accepted request always makes the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("busy not raised after accepted request");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> !i_busy)
        else $error("result strobe while still busy");

    a_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> !i_done)
        else $error("result in cycle straight after acceptance");

    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && i_rejected) |-> (i_result_index == '0))
        else $error("rejected request returned non-zero index");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_busy) |-> $past(i_start))
        else $error("busy raised without a request");

endmodule

bind timestamp_lru_device_table tld_checker u_tld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_done         (o_done),
    .i_result_index (o_result_index),
    .i_rejected     (o_rejected)
);
